// ===== rtl/argb8888_over_rgb565_blend_assert.svh =====
// Assertion macros for the ARGB8888-over-RGB565 blender.
`ifndef ARGB8888_OVER_RGB565_BLEND_ASSERT_SVH
`define ARGB8888_OVER_RGB565_BLEND_ASSERT_SVH
`ifndef SYNTHESIS
`define AB565_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define AB565_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define AB565_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AB565_ASSERT(lbl, prop, msg)
`define AB565_ASSERT_IMP(lbl, ante, cons, msg)
`define AB565_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/ab565_pkg.sv =====
// Shared types and constants for the ARGB8888-over-RGB565 blender.
package ab565_pkg;

  localparam int unsigned SRC_W   = 32;
  localparam int unsigned DST_W   = 16;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned KEY_W   = 24;
  localparam int unsigned CFG_D_W = 24;

  localparam logic [CH_W-1:0] ALPHA_FULL  = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_CLEAR = 8'h00;

  typedef enum logic [1:0] {
    REG_GLOBAL_ALPHA  = 2'd0,
    REG_CHROMA_ENABLE = 2'd1,
    REG_KEY_COLOR     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0]  global_alpha;
    logic             chroma_enable;
    logic [KEY_W-1:0] key_color;
  } cfg_t;

endpackage

// ===== rtl/ab565_if.sv =====
// Channel interfaces: pixel requests, blend results and register writes.
interface ab565_pix_if import ab565_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] src_pixel;
  logic [DST_W-1:0] dst_pixel;

  modport source (output valid, src_pixel, dst_pixel, input ready);
  modport sink   (input valid, src_pixel, dst_pixel, output ready);
endinterface

interface ab565_res_if import ab565_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DST_W-1:0] new_pixel;
  logic             write_enable;

  modport source (output valid, new_pixel, write_enable, input ready);
  modport sink   (input valid, new_pixel, write_enable, output ready);
endinterface

interface ab565_cfg_if import ab565_pkg::*; ();
  logic               valid;
  logic               ready;
  cfg_reg_e           index;
  logic [CFG_D_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/argb8888_over_rgb565_blend.sv =====
// ARGB8888-over-RGB565 alpha blender with chroma key, top level.
//
// Blends one ARGB8888 source pixel over one RGB565 destination pixel per
// request and returns the new RGB565 value with a write flag. The datapath
// is a four-stage pipeline (input capture; skip test and alpha product;
// weight select and channel products; sum, scale and pack into the output
// register), and a new request is taken every cycle while results drain.
// Backpressure on the result channel stalls the stages from the output
// backward; a bubble in any stage is filled while later stages wait. Write
// registers only while the pipeline is empty.
`include "argb8888_over_rgb565_blend_assert.svh"
module argb8888_over_rgb565_blend import ab565_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ab565_cfg_if.sink  cfg_i,
  ab565_pix_if.sink  pix_i,
  ab565_res_if.source res_o
);

  cfg_t cfg;

  ab565_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || res_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign pix_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: capture request.
  logic [SRC_W-1:0] src1_q;
  logic [DST_W-1:0] dst1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      src1_q <= pix_i.src_pixel;
      dst1_q <= pix_i.dst_pixel;
    end
  end

  // Stage 2: skip decision and composite alpha product.
  logic [CH_W-1:0]   sa1;
  logic              skip1;
  logic [2*CH_W-1:0] prod1;

  assign sa1   = src1_q[SRC_W-1 -: CH_W];
  assign skip1 = (cfg.global_alpha == ALPHA_CLEAR)
              || (cfg.chroma_enable && (src1_q[KEY_W-1:0] == cfg.key_color))
              || (sa1 == ALPHA_CLEAR);
  assign prod1 = {{CH_W{1'b0}}, cfg.global_alpha} * {{CH_W{1'b0}}, sa1};

  logic             skip2_q;
  logic [CH_W-1:0]  sa2_q;
  logic [CH_W-1:0]  comp2_q;
  logic [KEY_W-1:0] rgb2_q;
  logic [DST_W-1:0] dst2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      skip2_q <= skip1;
      sa2_q   <= sa1;
      comp2_q <= prod1[2*CH_W-1:CH_W];
      rgb2_q  <= src1_q[KEY_W-1:0];
      dst2_q  <= dst1_q;
    end
  end

  // Stage 3: weight select and channel products.
  logic [CH_W-1:0] w2;

  always_comb begin
    if (cfg.global_alpha == ALPHA_FULL) begin
      w2 = sa2_q;
    end else if (sa2_q == ALPHA_FULL) begin
      w2 = cfg.global_alpha;
    end else begin
      w2 = comp2_q;
    end
  end

  logic [CH_W-1:0] r3, g3, b3;

  ab565_mix u_mix_r (
    .clk_i  (clk_i),
    .en_i   (en3),
    .fg_i   (rgb2_q[23:16]),
    .bg_i   ({dst2_q[15:11], 3'b000}),
    .w_i    (w2),
    .chan_o (r3)
  );

  ab565_mix u_mix_g (
    .clk_i  (clk_i),
    .en_i   (en3),
    .fg_i   (rgb2_q[15:8]),
    .bg_i   ({dst2_q[10:5], 2'b00}),
    .w_i    (w2),
    .chan_o (g3)
  );

  ab565_mix u_mix_b (
    .clk_i  (clk_i),
    .en_i   (en3),
    .fg_i   (rgb2_q[7:0]),
    .bg_i   ({dst2_q[4:0], 3'b000}),
    .w_i    (w2),
    .chan_o (b3)
  );

  logic             skip3_q;
  logic [DST_W-1:0] dst3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      skip3_q <= skip2_q;
      dst3_q  <= dst2_q;
    end
  end

  // Stage 4: sum, truncate to 565 and hold the result.
  logic [DST_W-1:0] pix4_q;
  logic             we4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      pix4_q <= skip3_q ? dst3_q : {r3[7:3], g3[7:2], b3[7:3]};
      we4_q  <= !skip3_q;
    end
  end

  assign res_o.valid        = v4_q;
  assign res_o.new_pixel    = pix4_q;
  assign res_o.write_enable = we4_q;

  // A stalled stage 1 keeps its request.
  `AB565_ASSERT_NXT(a_s1_hold, v1_q && !en2, v1_q && $stable(src1_q) && $stable(dst1_q),
    "stage 1 request changed while stalled")
  // Global alpha of zero must mark the request as skipped.
  `AB565_ASSERT_NXT(a_ga_zero_skip, v1_q && en2 && (cfg.global_alpha == ALPHA_CLEAR),
    v2_q && skip2_q, "global alpha zero did not skip")
  // A skipped result carries the destination pixel unchanged.
  `AB565_ASSERT_NXT(a_skip_passthru, v3_q && en4 && skip3_q,
    !res_o.write_enable && (res_o.new_pixel == $past(dst3_q)),
    "skipped result altered the destination pixel")

endmodule

// ===== rtl/ab565_cfg.sv =====
// Blend configuration registers.
module ab565_cfg import ab565_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ab565_cfg_if.sink   cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_GLOBAL_ALPHA:  cfg_d.global_alpha  = cfg_i.data[CH_W-1:0];
        REG_CHROMA_ENABLE: cfg_d.chroma_enable = cfg_i.data[0];
        REG_KEY_COLOR:     cfg_d.key_color     = cfg_i.data[KEY_W-1:0];
        default: ;  // drop writes to unmapped registers
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.global_alpha  <= ALPHA_FULL;
      cfg_q.chroma_enable <= 1'b0;
      cfg_q.key_color     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ab565_mix.sv =====
// One color channel: registered weighted products, then sum and scale.
module ab565_mix import ab565_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [CH_W-1:0] fg_i,
  input  logic [CH_W-1:0] bg_i,
  input  logic [CH_W-1:0] w_i,
  output logic [CH_W-1:0] chan_o
);

  logic [CH_W:0]     inv_w;
  logic [2*CH_W-1:0] fg_prod_q;
  logic [2*CH_W:0]   bg_prod_q;
  logic [2*CH_W:0]   sum;

  // 256 - w, nine bits
  assign inv_w = {1'b1, {CH_W{1'b0}}} - {1'b0, w_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fg_prod_q <= {{CH_W{1'b0}}, fg_i} * {{CH_W{1'b0}}, w_i};
      bg_prod_q <= {{(CH_W+1){1'b0}}, bg_i} * {{CH_W{1'b0}}, inv_w};
    end
  end

  // Sum never exceeds 255*256, so the top bit stays clear.
  assign sum    = {1'b0, fg_prod_q} + bg_prod_q;
  assign chan_o = sum[2*CH_W-1:CH_W];

endmodule

// ===== tb/argb8888_over_rgb565_blend_tb.sv =====
// Self-checking testbench for the ARGB8888-over-RGB565 blender.
`timescale 1ns / 1ps
module argb8888_over_rgb565_blend_tb;
  import ab565_pkg::*;

  localparam logic [1:0]  REG_IDX_UNUSED = 2'd3;
  localparam int unsigned MAX_WAIT       = 14;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS    = 40;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [DST_W-1:0] new_pixel;
    logic             write_enable;
  } blend_result_t;

  typedef struct {
    logic [SRC_W-1:0] src;
    logic [DST_W-1:0] dst;
    blend_result_t    result;
  } pending_blend_t;

  logic clk_i;
  logic rst_ni;

  ab565_cfg_if cfg_bus();
  ab565_pix_if pix_bus();
  ab565_res_if res_bus();

  argb8888_over_rgb565_blend dut (
    .clk_i,
    .rst_ni,
    .cfg_i (cfg_bus),
    .pix_i (pix_bus),
    .res_o (res_bus)
  );

  cfg_t           shadow_cfg;
  pending_blend_t expected_blends[$];
  int unsigned    mismatch_count;
  bit             idle_on;

  function automatic int unsigned weigh_channel(int unsigned fg, int unsigned bg,
                                                int unsigned w);
    return (fg * w + bg * (256 - w)) >> 8;
  endfunction

  function automatic blend_result_t predict_blend(cfg_t c, logic [SRC_W-1:0] src,
                                                  logic [DST_W-1:0] dst);
    blend_result_t res;
    int unsigned   ga, sa, w, r, g, b;
    ga = 32'(c.global_alpha);
    sa = 32'(src[31:24]);
    res.new_pixel    = dst;
    res.write_enable = 1'b0;
    if (c.global_alpha == ALPHA_CLEAR || src[31:24] == ALPHA_CLEAR ||
        (c.chroma_enable && src[KEY_W-1:0] == c.key_color)) begin
      return res;
    end
    if (c.global_alpha == ALPHA_FULL) begin
      w = sa;
    end else if (src[31:24] == ALPHA_FULL) begin
      w = ga;
    end else begin
      w = (ga * sa) >> 8;
    end
    // widen the 565 background with zero fill
    r = weigh_channel(32'(src[23:16]), 32'({dst[15:11], 3'b000}), w);
    g = weigh_channel(32'(src[15:8]), 32'({dst[10:5], 2'b00}), w);
    b = weigh_channel(32'(src[7:0]), 32'({dst[4:0], 3'b000}), w);
    res.new_pixel    = {r[7:3], g[7:2], b[7:3]};
    res.write_enable = 1'b1;
    return res;
  endfunction

  function automatic int unsigned draw_wait();
    return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  task automatic send_pixel(logic [SRC_W-1:0] src, logic [DST_W-1:0] dst);
    pending_blend_t item;
    int unsigned    gap;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk_i);
      pix_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    pix_bus.valid     <= 1'b1;
    pix_bus.src_pixel <= src;
    pix_bus.dst_pixel <= dst;
    do @(posedge clk_i); while (pix_bus.ready !== 1'b1);
    item.src    = src;
    item.dst    = dst;
    item.result = predict_blend(shadow_cfg, src, dst);
    expected_blends.push_back(item);
  endtask

  // drop the request line and hold until every pending blend has come back
  task automatic drain_blends();
    @(negedge clk_i);
    pix_bus.valid <= 1'b0;
    wait (expected_blends.size() == 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_D_W-1:0] data);
    drain_blends();
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_GLOBAL_ALPHA:  shadow_cfg.global_alpha  = data[CH_W-1:0];
      REG_CHROMA_ENABLE: shadow_cfg.chroma_enable = data[0];
      REG_KEY_COLOR:     shadow_cfg.key_color     = data[KEY_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic note_failure(string detail);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, detail);
    end
    mismatch_count++;
  endtask

  // result side: random stalls, compare each accepted result with the oldest prediction
  initial begin : blend_checker
    pending_blend_t want;
    int unsigned    stall;
    res_bus.ready = 1'b0;
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk_i);
        res_bus.ready <= 1'b0;
      end
      @(negedge clk_i);
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni === 1'b1 && res_bus.valid === 1'b1));
      if (expected_blends.size() == 0) begin
        note_failure($sformatf("unexpected result: pixel %h we %b",
                               res_bus.new_pixel, res_bus.write_enable));
      end else begin
        want = expected_blends.pop_front();
        if (res_bus.new_pixel !== want.result.new_pixel ||
            res_bus.write_enable !== want.result.write_enable) begin
          note_failure($sformatf(
              "src %h dst %h: expected pixel %h we %b, got pixel %h we %b",
              want.src, want.dst, want.result.new_pixel, want.result.write_enable,
              res_bus.new_pixel, res_bus.write_enable));
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_pixel(32'h0012_3456, 16'hFFFF);
    send_pixel(32'hFFFF_FFFF, 16'h0000);
    send_pixel(32'hFF00_0000, 16'hFFFF);
    send_pixel(32'h80FF_00FF, 16'h07E0);
    send_pixel(32'h01FF_FFFF, 16'hA5A5);
    send_pixel(32'hFE00_0000, 16'hFFFF);
  endtask

  task automatic test_global_alpha();
    // upper data bits must be ignored
    write_reg(REG_GLOBAL_ALPHA, {16'hFFFF, 8'h00});
    send_pixel(32'hFFFF_FFFF, 16'h1234);
    write_reg(REG_GLOBAL_ALPHA, {16'h0000, 8'h80});
    send_pixel(32'hFF12_3456, 16'hFFFF);
    // composite weight rounds to zero: written, pixel unchanged
    send_pixel(32'h01FF_FFFF, 16'h0000);
    send_pixel(32'hC8A0_50F0, 16'h5A5A);
    write_reg(REG_GLOBAL_ALPHA, {16'h5555, 8'h01});
    send_pixel(32'hFEFF_FFFF, 16'h0000);
    send_pixel(32'hFFFF_FFFF, 16'h0000);
    write_reg(REG_GLOBAL_ALPHA, {16'h0000, 8'hFE});
    send_pixel(32'hFE80_4020, 16'h5555);
    write_reg(REG_GLOBAL_ALPHA, {16'h0000, ALPHA_FULL});
  endtask

  task automatic test_chroma_key();
    write_reg(REG_KEY_COLOR, 24'h12_3456);
    write_reg(REG_CHROMA_ENABLE, {23'h7F_FFFF, 1'b1});
    send_pixel(32'hFF12_3456, 16'hF81F);
    send_pixel(32'h8012_3456, 16'h07E0);
    send_pixel(32'hFF12_3457, 16'hF81F);
    send_pixel(32'hFF92_3456, 16'h0000);
    write_reg(REG_KEY_COLOR, 24'hFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 16'h0000);
    send_pixel(32'h00FF_FFFF, 16'h1111);
    write_reg(REG_KEY_COLOR, 24'h00_0000);
    send_pixel(32'hFF00_0000, 16'hFFFF);
    write_reg(REG_CHROMA_ENABLE, {23'h00_0000, 1'b0});
    send_pixel(32'hFF00_0000, 16'hFFFF);
  endtask

  task automatic test_unused_index();
    // a write to an unmapped index must leave every register alone
    write_reg(cfg_reg_e'(REG_IDX_UNUSED), 24'hFF_FFFF);
    send_pixel(32'h80FF_FFFF, 16'h0000);
    send_pixel(32'hFF00_0000, 16'hFFFF);
  endtask

  task automatic test_random_traffic();
    logic [CH_W-1:0]  ga, alpha;
    logic [KEY_W-1:0] key, rgb;
    logic             enable;
    int unsigned      sel;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase % 3 != 1);
      sel = (phase < 4) ? phase : $urandom_range(0, 5);
      case (sel)
        0:       ga = ALPHA_FULL;
        1:       ga = ALPHA_CLEAR;
        2:       ga = 8'h01;
        3:       ga = 8'hFE;
        default: ga = 8'($urandom_range(0, 255));
      endcase
      enable = (phase < 2) ? 1'(phase % 2) : 1'($urandom_range(0, 1));
      if (phase == 2) begin
        key = '0;
      end else if (phase == 3) begin
        key = '1;
      end else begin
        key = 24'($urandom());
      end
      write_reg(REG_GLOBAL_ALPHA, {16'($urandom()), ga});
      write_reg(REG_CHROMA_ENABLE, {23'($urandom()), enable});
      write_reg(REG_KEY_COLOR, key);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && phase % 2 == 0) begin
          drain_blends();
        end
        case ($urandom_range(0, 5))
          0:       alpha = ALPHA_CLEAR;
          1:       alpha = ALPHA_FULL;
          default: alpha = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 3) == 0) begin
          // hit the key exactly or miss it by one bit
          rgb = shadow_cfg.key_color;
          if ($urandom_range(0, 1) == 1) begin
            rgb[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
          end
        end else begin
          rgb = 24'($urandom());
        end
        send_pixel({alpha, rgb}, 16'($urandom()));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("argb8888_over_rgb565_blend verification failed");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    pix_bus.valid     = 1'b0;
    pix_bus.src_pixel = '0;
    pix_bus.dst_pixel = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_GLOBAL_ALPHA;
    cfg_bus.data      = '0;
    shadow_cfg        = '{global_alpha: ALPHA_FULL, chroma_enable: 1'b0, key_color: '0};
    mismatch_count    = 0;
    idle_on           = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_global_alpha();
    test_chroma_key();
    test_unused_index();
    test_random_traffic();

    drain_blends();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_blends.size() == 0) begin
      $display("argb8888_over_rgb565_blend verification clean");
    end else begin
      $display("argb8888_over_rgb565_blend verification failed");
    end
    $finish;
  end

endmodule
